/* rtl/fsrf_pkg.sv */
// Shared constants, control-word layout and microcode program for the
// force estimator with debounced stop. No dependencies.
`default_nettype none
package fsrf_pkg;

    localparam int ADC_BITS_DEF = 10;
    localparam int APB_AW       = 2;
    localparam int APB_DW       = 32;
    localparam int DEB_W        = 16;
    localparam int TS_W         = 32;
    localparam int DUTY_W       = 8;
    localparam int FORCE_W      = 16;

    localparam logic [DEB_W-1:0] DEBOUNCE_RST = 16'd50;

    // shared restoring divider: 26-bit dividend, two quotient bits per cycle
    localparam int DIV_W     = 26;
    localparam int DIV_RADIX = 2;
    localparam int DIV_ITERS = DIV_W / DIV_RADIX;
    localparam int CNT_W     = $clog2(DIV_ITERS);

    localparam int VCC_MV      = 5000;
    localparam int SERIES_OHMS = 10000;
    localparam int COND_SCALE  = 1000000;
    localparam int KNEE        = 1000;
    localparam int SLOPE_LOW   = 80;
    localparam int SLOPE_HIGH  = 30;
    localparam int DUTY_MAX    = 255;
    localparam int FORCE_MAX   = 33300;

    localparam int MV_W = 13;

    // datapath operations
    localparam logic [3:0] OP_NOP       = 4'd0;
    localparam logic [3:0] OP_ACCEPT    = 4'd1;
    localparam logic [3:0] OP_DIV       = 4'd2;
    localparam logic [3:0] OP_LD_MV     = 4'd3;
    localparam logic [3:0] OP_LD_RES    = 4'd4;
    localparam logic [3:0] OP_LD_COND   = 4'd5;
    localparam logic [3:0] OP_LD_FORCE  = 4'd6;
    localparam logic [3:0] OP_SET_FORCE = 4'd7;
    localparam logic [3:0] OP_EMIT      = 4'd8;

    // jump conditions
    localparam logic [2:0] JC_NEXT        = 3'd0;
    localparam logic [2:0] JC_NO_IN       = 3'd1;
    localparam logic [2:0] JC_STOP        = 3'd2;
    localparam logic [2:0] JC_DIV_BUSY    = 3'd3;
    localparam logic [2:0] JC_MV_ZERO     = 3'd4;
    localparam logic [2:0] JC_RES_ZERO    = 3'd5;
    localparam logic [2:0] JC_OUT_BLOCKED = 3'd6;

    // program steps
    localparam logic [3:0] ST_WAIT      = 4'd0;
    localparam logic [3:0] ST_CHK_STOP  = 4'd1;
    localparam logic [3:0] ST_DIV_DUTY  = 4'd2;
    localparam logic [3:0] ST_LD_MV     = 4'd3;
    localparam logic [3:0] ST_DIV_MV    = 4'd4;
    localparam logic [3:0] ST_LD_RES    = 4'd5;
    localparam logic [3:0] ST_DIV_RES   = 4'd6;
    localparam logic [3:0] ST_LD_COND   = 4'd7;
    localparam logic [3:0] ST_DIV_COND  = 4'd8;
    localparam logic [3:0] ST_LD_FORCE  = 4'd9;
    localparam logic [3:0] ST_DIV_FORCE = 4'd10;
    localparam logic [3:0] ST_SET_FORCE = 4'd11;
    localparam logic [3:0] ST_EMIT      = 4'd12;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] cond;
        logic [3:0] target;
        logic       fin;
    } t_uword;

    function automatic t_uword f_ucode(input logic [3:0] step);
        t_uword uw;
        uw = '{op: OP_NOP, cond: JC_NEXT, target: ST_WAIT, fin: 1'b1};
        case (step)
            ST_WAIT:      uw = '{op: OP_ACCEPT,    cond: JC_NO_IN,       target: ST_WAIT,
                                 fin: 1'b0};
            ST_CHK_STOP:  uw = '{op: OP_NOP,       cond: JC_STOP,        target: ST_EMIT,
                                 fin: 1'b0};
            ST_DIV_DUTY:  uw = '{op: OP_DIV,       cond: JC_DIV_BUSY,    target: ST_DIV_DUTY,
                                 fin: 1'b0};
            ST_LD_MV:     uw = '{op: OP_LD_MV,     cond: JC_NEXT,        target: ST_WAIT,
                                 fin: 1'b0};
            ST_DIV_MV:    uw = '{op: OP_DIV,       cond: JC_DIV_BUSY,    target: ST_DIV_MV,
                                 fin: 1'b0};
            ST_LD_RES:    uw = '{op: OP_LD_RES,    cond: JC_MV_ZERO,     target: ST_EMIT,
                                 fin: 1'b0};
            ST_DIV_RES:   uw = '{op: OP_DIV,       cond: JC_DIV_BUSY,    target: ST_DIV_RES,
                                 fin: 1'b0};
            ST_LD_COND:   uw = '{op: OP_LD_COND,   cond: JC_RES_ZERO,    target: ST_LD_FORCE,
                                 fin: 1'b0};
            ST_DIV_COND:  uw = '{op: OP_DIV,       cond: JC_DIV_BUSY,    target: ST_DIV_COND,
                                 fin: 1'b0};
            ST_LD_FORCE:  uw = '{op: OP_LD_FORCE,  cond: JC_NEXT,        target: ST_WAIT,
                                 fin: 1'b0};
            ST_DIV_FORCE: uw = '{op: OP_DIV,       cond: JC_DIV_BUSY,    target: ST_DIV_FORCE,
                                 fin: 1'b0};
            ST_SET_FORCE: uw = '{op: OP_SET_FORCE, cond: JC_NEXT,        target: ST_WAIT,
                                 fin: 1'b0};
            ST_EMIT:      uw = '{op: OP_EMIT,      cond: JC_OUT_BLOCKED, target: ST_EMIT,
                                 fin: 1'b1};
            default:      uw = '{op: OP_NOP,       cond: JC_NEXT,        target: ST_WAIT,
                                 fin: 1'b1};
        endcase
        return uw;
    endfunction

endpackage
`default_nettype wire

/* rtl/fsr_force_with_debounced_stop.sv */
// Top level: microcoded force estimator with debounced stop button.
// Depends on fsrf_pkg (constants, control word, microcode program).
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one sampling pass: timestamp,
//   raw button level and converter sample. Output channel (o_out_valid /
//   i_out_ready) returns exactly one result per item: stop flag, LED duty and
//   force in newtons. The APB port holds debounce_ms at address 0.
//   A step counter walks a 13-word program; each word picks one datapath
//   operation and a conditional jump. All divisions share one restoring
//   divider that retires two quotient bits per cycle.
//   A full estimate runs every step. A stop result goes from the stop check
//   straight to emit; zero millivolts go from the resistance load to emit; at
//   full scale the conductance divide is skipped. The divider loops dominate.
//   The next item is accepted in the cycle after the result is registered,
//   while that result still waits to be taken.
//   If the receiver stalls, the program holds on its last step until the
//   output register frees, then writes the new result.
//   Reset (synchronous, active low) restores debounce_ms to 50, the button
//   history to released, and clears the stop latch; no clearing pass.
`default_nettype none
module fsr_force_with_debounced_stop #(
    parameter int ADC_BITS = fsrf_pkg::ADC_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [fsrf_pkg::TS_W-1:0]    i_now_ms,
    input  wire logic                         i_button_level,
    input  wire logic [ADC_BITS-1:0]          i_adc_sample,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic                              o_stopped,
    output logic [fsrf_pkg::DUTY_W-1:0]       o_led_duty,
    output logic [fsrf_pkg::FORCE_W-1:0]      o_force_newtons,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [fsrf_pkg::APB_AW-1:0]  paddr,
    input  wire logic [fsrf_pkg::APB_DW-1:0]  pwdata,
    output logic [fsrf_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);
    import fsrf_pkg::*;

    localparam logic [DIV_W-1:0] FULL_SCALE = DIV_W'((1 << ADC_BITS) - 1);
    localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(DIV_ITERS - 1);
    localparam logic [APB_AW-1:0] ADDR_DEBOUNCE = '0;

    // control
    logic [3:0]        r_step, n_step;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_stop, n_stop;
    logic              r_halted, n_halted;
    logic              r_prev, n_prev;
    logic              r_settled, n_settled;
    logic [TS_W-1:0]   r_last, n_last;
    logic [DEB_W-1:0]  r_deb, n_deb;
    logic              r_out_valid, n_out_valid;

    // datapath
    logic [DIV_W-1:0]   r_rem, n_rem;
    logic [DIV_W-1:0]   r_quo, n_quo;
    logic [DIV_W-1:0]   r_dsr, n_dsr;
    logic [DUTY_W-1:0]  r_duty, n_duty;
    logic [FORCE_W-1:0] r_force, n_force;
    logic               r_o_stop, n_o_stop;
    logic [DUTY_W-1:0]  r_o_duty, n_o_duty;
    logic [FORCE_W-1:0] r_o_force, n_o_force;

    t_uword            uw;
    logic              in_fire;
    logic              out_blocked;
    logic              take;
    logic              cfg_wr;
    logic [DIV_W:0]    d_rem;
    logic [DIV_W-1:0]  d_quo;
    logic [TS_W-1:0]   lc_ms;
    logic [TS_W-1:0]   elapsed;
    logic [MV_W-1:0]   mv;

    assign uw          = f_ucode(r_step);
    assign o_in_ready  = (r_step == ST_WAIT);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_blocked = r_out_valid && !i_out_ready;
    assign cfg_wr      = psel && penable && pwrite && pready;
    assign pready      = 1'b1;
    assign prdata      = (paddr == ADDR_DEBOUNCE) ? APB_DW'(r_deb) : '0;

    assign o_out_valid     = r_out_valid;
    assign o_stopped       = r_o_stop;
    assign o_led_duty      = r_o_duty;
    assign o_force_newtons = r_o_force;

    assign mv      = r_quo[MV_W-1:0];
    assign lc_ms   = (i_button_level != r_prev) ? i_now_ms : r_last;
    assign elapsed = i_now_ms - lc_ms;

    // two restoring division steps
    always_comb begin
        d_rem = {1'b0, r_rem};
        d_quo = r_quo;
        for (int k = 0; k < DIV_RADIX; k++) begin
            d_rem = {d_rem[DIV_W-1:0], d_quo[DIV_W-1]};
            d_quo = {d_quo[DIV_W-2:0], 1'b0};
            if (d_rem >= {1'b0, r_dsr}) begin
                d_rem    = d_rem - {1'b0, r_dsr};
                d_quo[0] = 1'b1;
            end
        end
    end

    // jump decision
    always_comb begin
        case (uw.cond)
            JC_NEXT:        take = 1'b0;
            JC_NO_IN:       take = !in_fire;
            JC_STOP:        take = r_stop;
            JC_DIV_BUSY:    take = (r_cnt != CNT_LAST);
            JC_MV_ZERO:     take = (r_quo == '0);
            JC_RES_ZERO:    take = (r_quo == '0);
            JC_OUT_BLOCKED: take = out_blocked;
            default:        take = 1'b0;
        endcase
        if (take) begin
            n_step = uw.target;
        end else if (uw.fin) begin
            n_step = ST_WAIT;
        end else begin
            n_step = r_step + 4'd1;
        end
    end

    always_comb begin
        n_cnt       = r_cnt;
        n_stop      = r_stop;
        n_halted    = r_halted;
        n_prev      = r_prev;
        n_settled   = r_settled;
        n_last      = r_last;
        n_deb       = r_deb;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_dsr       = r_dsr;
        n_duty      = r_duty;
        n_force     = r_force;
        n_o_stop    = r_o_stop;
        n_o_duty    = r_o_duty;
        n_o_force   = r_o_force;
        n_out_valid = r_out_valid;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (cfg_wr) begin
            n_deb = pwdata[DEB_W-1:0];
        end

        case (uw.op)
            OP_ACCEPT: begin
                if (in_fire) begin
                    n_rem = '0;
                    n_cnt = '0;
                    n_quo = DIV_W'(i_adc_sample) * DIV_W'(DUTY_MAX);
                    n_dsr = FULL_SCALE;
                    n_stop = 1'b0;
                    if (r_halted) begin
                        n_stop = 1'b1;
                    end else begin
                        n_last = lc_ms;
                        n_prev = i_button_level;
                        if (elapsed > TS_W'(r_deb) && i_button_level != r_settled) begin
                            n_settled = i_button_level;
                            if (!i_button_level) begin
                                // settled press: latch stop, keep raw history
                                n_halted = 1'b1;
                                n_stop   = 1'b1;
                                n_prev   = r_prev;
                            end
                        end
                    end
                end
            end
            OP_DIV: begin
                n_rem = d_rem[DIV_W-1:0];
                n_quo = d_quo;
                n_cnt = r_cnt + CNT_W'(1);
            end
            OP_LD_MV: begin
                n_duty = r_quo[DUTY_W-1:0];
                n_rem  = '0;
                n_cnt  = '0;
                n_quo  = DIV_W'(r_quo[DUTY_W-1:0]) * DIV_W'(VCC_MV);
                n_dsr  = DIV_W'(DUTY_MAX);
            end
            OP_LD_RES: begin
                n_force = '0;
                n_rem   = '0;
                n_cnt   = '0;
                n_quo   = DIV_W'(MV_W'(VCC_MV) - mv) * DIV_W'(SERIES_OHMS);
                n_dsr   = DIV_W'(mv);
            end
            OP_LD_COND: begin
                // zero resistance skips the divide: conductance saturates
                n_rem = '0;
                n_cnt = '0;
                n_quo = DIV_W'(COND_SCALE);
                n_dsr = r_quo;
            end
            OP_LD_FORCE: begin
                n_rem = '0;
                n_cnt = '0;
                if (r_quo <= DIV_W'(KNEE)) begin
                    n_quo = r_quo;
                    n_dsr = DIV_W'(SLOPE_LOW);
                end else begin
                    n_quo = r_quo - DIV_W'(KNEE);
                    n_dsr = DIV_W'(SLOPE_HIGH);
                end
            end
            OP_SET_FORCE: begin
                n_force = r_quo[FORCE_W-1:0];
            end
            OP_EMIT: begin
                if (!out_blocked) begin
                    n_out_valid = 1'b1;
                    n_o_stop    = r_stop;
                    n_o_duty    = r_stop ? '0 : r_duty;
                    n_o_force   = r_stop ? '0 : r_force;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ST_WAIT;
            r_cnt       <= '0;
            r_stop      <= 1'b0;
            r_halted    <= 1'b0;
            r_prev      <= 1'b1;
            r_settled   <= 1'b1;
            r_last      <= '0;
            r_deb       <= DEBOUNCE_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_cnt       <= n_cnt;
            r_stop      <= n_stop;
            r_halted    <= n_halted;
            r_prev      <= n_prev;
            r_settled   <= n_settled;
            r_last      <= n_last;
            r_deb       <= n_deb;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_dsr     <= n_dsr;
        r_duty    <= n_duty;
        r_force   <= n_force;
        r_o_stop  <= n_o_stop;
        r_o_duty  <= n_o_duty;
        r_o_force <= n_o_force;
    end

    a_stop_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_stop) |-> (r_o_duty == '0 && r_o_force == '0))
        else $error("stop item carries nonzero fields");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("stop latch released without reset");

    a_force_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_o_stop) |-> (r_o_force <= FORCE_W'(FORCE_MAX)))
        else $error("force estimate out of range");

    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == ST_EMIT && out_blocked) |=> (r_step == ST_EMIT))
        else $error("sequencer left emit step while output busy");

endmodule
`default_nettype wire
